FILE: rtl/core/pfs_pkg.sv
package pfs_pkg;

   localparam int FRAME_BITS = 24;
   localparam int FRAC_BITS  = 8;

   localparam int FIELD_W = 24;
   localparam int SPEED_W = 16;
   localparam int PCT_W   = 16;
   localparam int OP_W    = 3;
   localparam int MODE_W  = 2;
   localparam int IDX_W   = 2;

   localparam int POS_W     = FRAME_BITS + FRAC_BITS;
   localparam int EXT_W     = (FRAME_BITS > FIELD_W) ? FRAME_BITS : FIELD_W;
   localparam int UP_SHIFT  = (FRAC_BITS >= 8) ? (FRAC_BITS - 8) : 0;
   localparam int DOWN_SHIFT = (FRAC_BITS < 8) ? (8 - FRAC_BITS) : 0;
   localparam int SPD_W     = SPEED_W + 1 + UP_SHIFT;
   localparam int NP_W      = ((POS_W > SPD_W) ? POS_W : SPD_W) + 2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_PLAY    = 3'd1,
      OP_STOP    = 3'd2,
      OP_PAUSE   = 3'd3,
      OP_RESUME  = 3'd4,
      OP_SET_FRM = 3'd5,
      OP_SET_POS = 3'd6
   } op_type;

   localparam logic [MODE_W-1:0] MODE_WRAP   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd2;

   localparam logic [IDX_W-1:0] CSR_TOTAL = 2'd0;
   localparam logic [IDX_W-1:0] CSR_MODE  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_SPEED = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0]        total;
      logic [MODE_W-1:0]         mode;
      logic signed [SPEED_W-1:0] speed;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             playing;
      logic             reversed;
   } state_type;

   function automatic logic [FRAME_BITS-1:0] to_frame(input logic [FIELD_W-1:0] v);
      logic [EXT_W-1:0] e;
      e = EXT_W'(v);
      return e[FRAME_BITS-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] from_frame(input logic [FRAME_BITS-1:0] f);
      logic [EXT_W-1:0] e;
      e = EXT_W'(f);
      return e[FIELD_W-1:0];
   endfunction

endpackage

FILE: rtl/core/pfs_csr.sv
module pfs_csr
   import pfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [FIELD_W-1:0] csr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TOTAL: cfg_in.total = csr_data;
            CSR_MODE:  cfg_in.mode  = csr_data[MODE_W-1:0];
            CSR_SPEED: cfg_in.speed = $signed(csr_data[SPEED_W-1:0]);
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total <= FIELD_W'(1);
         cfg_ff.mode  <= MODE_WRAP;
         cfg_ff.speed <= SPEED_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/pfs_next.sv
module pfs_next
   import pfs_pkg::*;
(
   input  state_type          st,
   input  cfg_type            cfg,
   input  logic [OP_W-1:0]    op,
   input  logic [FIELD_W-1:0] frame_value,
   input  logic [PCT_W-1:0]   position_fraction,
   output state_type          nxt
);

   localparam logic signed [SPEED_W:0] DOWN_MASK = (SPEED_W+1)'((1 << DOWN_SHIFT) - 1);

   logic [FRAME_BITS-1:0]         tot_raw;
   logic [FRAME_BITS-1:0]         tot;
   logic [FRAME_BITS-1:0]         tot_last;
   logic [FRAME_BITS-1:0]         fv;
   logic [FRAME_BITS-1:0]         fv_sat;
   logic [POS_W-1:0]              limit;
   logic [POS_W-1:0]              last;
   logic signed [SPEED_W:0]       s_eff;
   logic signed [SPEED_W:0]       s_bias;
   logic signed [SPD_W-1:0]       spd;
   logic signed [NP_W-1:0]        np;
   logic                          high;
   logic                          low;
   logic [FRAME_BITS+PCT_W-1:0]   prod;

   always_comb begin
      tot_raw  = to_frame(cfg.total);
      tot      = (tot_raw == '0) ? FRAME_BITS'(1) : tot_raw;
      tot_last = tot - FRAME_BITS'(1);
      limit    = {tot, {FRAC_BITS{1'b0}}};
      last     = {tot_last, {FRAC_BITS{1'b0}}};

      s_eff  = st.reversed ? -$signed({cfg.speed[SPEED_W-1], cfg.speed})
                           : $signed({cfg.speed[SPEED_W-1], cfg.speed});
      s_bias = s_eff[SPEED_W] ? DOWN_MASK : '0;
      spd    = SPD_W'((s_eff + s_bias) >>> DOWN_SHIFT) <<< UP_SHIFT;

      np   = $signed(NP_W'(st.pos)) + NP_W'(spd);
      high = np >= $signed(NP_W'(limit));
      low  = np[NP_W-1];

      fv     = to_frame(frame_value);
      fv_sat = (fv >= tot) ? tot_last : fv;
      prod   = tot * position_fraction;

      nxt = st;
      case (op_type'(op)) inside
         OP_TICK: begin
            if (st.playing) begin
               nxt.pos = np[POS_W-1:0];
               if (high || low) begin
                  unique case (cfg.mode) inside
                     MODE_WRAP: begin
                        nxt.pos = high ? '0 : last;
                     end
                     MODE_BOUNCE: begin
                        nxt.pos      = high ? last : '0;
                        nxt.reversed = !st.reversed;
                     end
                     default: begin
                        nxt.pos     = '0;
                        nxt.playing = 1'b0;
                     end
                  endcase
               end
            end
         end
         OP_PLAY, OP_RESUME: begin
            nxt.playing = 1'b1;
         end
         OP_STOP: begin
            nxt.playing  = 1'b0;
            nxt.pos      = '0;
            nxt.reversed = cfg.speed[SPEED_W-1];
         end
         OP_PAUSE: begin
            nxt.playing = 1'b0;
         end
         OP_SET_FRM: begin
            nxt.pos = {fv_sat, {FRAC_BITS{1'b0}}};
         end
         OP_SET_POS: begin
            nxt.pos = POS_W'(prod >> (PCT_W - FRAC_BITS));
         end
         default: begin
            nxt = st;
         end
      endcase
   end

endmodule

FILE: rtl/core/playback_frame_sequencer_unit.sv
// Pipeline: a request waits in the request register and its result in the result register;
// a stalled result holds the request register until the result transfers.
// Throughput: one request per cycle while results are accepted; the position update is a single add,
// range compare and select between the request register and the result register.
// Reset: synchronous, active high; position 0, stopped, forward, total 1,
// wrap mode, speed 1.0, and both pipeline registers empty.
module playback_frame_sequencer_unit
   import pfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [FIELD_W-1:0] req_frame_value,
   input  logic [PCT_W-1:0]   req_position_fraction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_current_frame,
   output logic               rsp_is_playing,
   output logic               rsp_is_reversed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [FIELD_W-1:0] csr_data
);

   cfg_type            cfg;
   state_type          st_ff;
   state_type          st_in;
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [OP_W-1:0]    op_ff;
   logic [FIELD_W-1:0] fv_ff;
   logic [PCT_W-1:0]   pct_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [FIELD_W-1:0] frame_ff;
   logic               playing_ff;
   logic               reversed_ff;
   logic               advance;
   logic               req_take;

   pfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pfs_next u_next (
      .st                (st_ff),
      .cfg               (cfg),
      .op                (op_ff),
      .frame_value       (fv_ff),
      .position_fraction (pct_ff),
      .nxt               (st_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_opcode;
         fv_ff  <= req_frame_value;
         pct_ff <= req_position_fraction;
      end
      if (advance) begin
         frame_ff    <= from_frame(st_in.pos[POS_W-1:FRAC_BITS]);
         playing_ff  <= st_in.playing;
         reversed_ff <= st_in.reversed;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_current_frame = frame_ff;
   assign rsp_is_playing    = playing_ff;
   assign rsp_is_reversed   = reversed_ff;

endmodule

FILE: rtl/core/pfs_checker.sv
module pfs_checker
   import pfs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [OP_W-1:0]    req_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FIELD_W-1:0] rsp_current_frame,
   input logic               rsp_is_playing,
   input logic               rsp_is_reversed
);

   // A stalled result keeps its payload until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_frame)
         && $stable(rsp_is_playing) && $stable(rsp_is_reversed))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the result register empty the request register can always drain.
   a_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty result register");

   // A stop leaves the clip stopped at frame zero.
   a_stop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_STOP) && !rsp_valid) ##1 rsp_ready
         |=> rsp_valid && !rsp_is_playing && (rsp_current_frame == '0))
      else $error("stop did not report frame zero");

endmodule

bind playback_frame_sequencer_unit pfs_checker u_pfs_checker (.*);

FILE: tb/sv/pfs_status_checker.sv
`timescale 1ns / 1ps

module pfs_status_checker
   import pfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [FIELD_W-1:0] req_frame_value,
   input  logic [PCT_W-1:0]   req_position_fraction,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [FIELD_W-1:0] rsp_current_frame,
   input  logic               rsp_is_playing,
   input  logic               rsp_is_reversed,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [FIELD_W-1:0] csr_data,
   output int                 outstanding,
   output int                 mismatches
);

   typedef struct packed {
      logic [FIELD_W-1:0] frame;
      logic               playing;
      logic               reversed;
   } status_type;

   cfg_type    regs;
   state_type  track;
   status_type expected_status[$];
   int         fail_count = 0;

   function automatic status_type apply_command(input logic [OP_W-1:0]    op,
                                                input logic [FIELD_W-1:0] fv,
                                                input logic [PCT_W-1:0]   pct);
      longint     clip;
      longint     step;
      longint     next;
      status_type st;
      clip = (regs.total == '0) ? longint'(1) : longint'(regs.total);
      case (op)
         OP_TICK: begin
            if (track.playing) begin
               step = longint'($signed(regs.speed));
               if (track.reversed)
                  step = -step;
               if (FRAC_BITS >= 8)
                  step = step * (longint'(1) << UP_SHIFT);
               else
                  step = step / (longint'(1) << DOWN_SHIFT);
               next = longint'(track.pos) + step;
               if (next >= (clip << FRAC_BITS) || next < 0) begin
                  case (regs.mode)
                     MODE_WRAP: begin
                        next = (next < 0) ? ((clip - 1) << FRAC_BITS) : longint'(0);
                     end
                     MODE_BOUNCE: begin
                        next = (next < 0) ? longint'(0) : ((clip - 1) << FRAC_BITS);
                        track.reversed = !track.reversed;
                     end
                     default: begin
                        next = 0;
                        track.playing = 1'b0;
                     end
                  endcase
               end
               track.pos = POS_W'(next);
            end
         end
         OP_PLAY, OP_RESUME: track.playing = 1'b1;
         OP_STOP: begin
            track.playing  = 1'b0;
            track.pos      = '0;
            track.reversed = regs.speed[SPEED_W-1];
         end
         OP_PAUSE: track.playing = 1'b0;
         OP_SET_FRM: begin
            track.pos = POS_W'(((longint'(fv) >= clip) ? clip - 1 : longint'(fv)) << FRAC_BITS);
         end
         OP_SET_POS: track.pos = POS_W'((clip * longint'(pct)) >> (16 - FRAC_BITS));
         default: ;
      endcase
      st.frame    = FIELD_W'(track.pos >> FRAC_BITS);
      st.playing  = track.playing;
      st.reversed = track.reversed;
      return st;
   endfunction

   always @(posedge clock) begin
      status_type want;
      if (reset) begin
         regs.total  = FIELD_W'(1);
         regs.mode   = MODE_WRAP;
         regs.speed  = SPEED_W'(256);
         track       = '0;
         expected_status.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("result transfer with no expected status pending");
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_current_frame !== want.frame) begin
                  $error("current_frame: expected %0d, actual %0d",
                         want.frame, rsp_current_frame);
                  fail_count++;
               end
               if (rsp_is_playing !== want.playing) begin
                  $error("is_playing: expected %0d, actual %0d", want.playing, rsp_is_playing);
                  fail_count++;
               end
               if (rsp_is_reversed !== want.reversed) begin
                  $error("is_reversed: expected %0d, actual %0d",
                         want.reversed, rsp_is_reversed);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOTAL: regs.total = csr_data;
               CSR_MODE:  regs.mode  = csr_data[MODE_W-1:0];
               CSR_SPEED: regs.speed = csr_data[SPEED_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_status.push_back(apply_command(req_opcode, req_frame_value,
                                                    req_position_fraction));
      end
      outstanding <= expected_status.size();
      mismatches  <= fail_count;
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pfs_pkg::*;

   localparam logic [OP_W-1:0]   OP_UNUSED  = 3'd7;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic [IDX_W-1:0]  CSR_SPARE  = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   logic [OP_W-1:0]    req_opcode;
   logic [FIELD_W-1:0] req_frame_value;
   logic [PCT_W-1:0]   req_position_fraction;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FIELD_W-1:0] rsp_current_frame;
   logic               rsp_is_playing;
   logic               rsp_is_reversed;
   logic               csr_valid;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index;
   logic [FIELD_W-1:0] csr_data;
   int                 outstanding;
   int                 mismatches;
   int                 idle_pct = 0;
   int                 stall_left = 0;

   playback_frame_sequencer_unit dut (.*);

   pfs_status_checker checker_inst (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || idle_pct == 0) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct / 3) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic issue(input logic [OP_W-1:0]    op,
                        input logic [FIELD_W-1:0] fv,
                        input logic [PCT_W-1:0]   pct);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_opcode            <= op;
      req_frame_value       <= fv;
      req_position_fraction <= pct;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [FIELD_W-1:0] total;
      logic [FIELD_W-1:0] word;
      logic [FIELD_W-1:0] fv;
      logic [SPEED_W-1:0] spd;
      logic [MODE_W-1:0]  mode;
      logic [OP_W-1:0]    op;
      int                 r;
      int                 mag;

      req_valid             = 1'b0;
      req_opcode            = OP_TICK;
      req_frame_value       = '0;
      req_position_fraction = '0;
      csr_valid             = 1'b0;
      csr_index             = CSR_TOTAL;
      csr_data              = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_PLAY, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_TOTAL, 24'd0);
      issue(OP_SET_FRM, 24'd5, PCT_W'($urandom));
      issue(OP_SET_POS, FIELD_W'($urandom), 16'hFFFF);
      write_reg(CSR_TOTAL, 24'hFFFFFF);
      issue(OP_SET_FRM, 24'hFFFFFF, PCT_W'($urandom));
      issue(OP_SET_POS, FIELD_W'($urandom), 16'hFFFF);
      issue(OP_SET_POS, FIELD_W'($urandom), 16'h0000);
      write_reg(CSR_TOTAL, 24'd8);
      write_reg(CSR_MODE, {22'h3FFFFF, MODE_BOUNCE});
      write_reg(CSR_SPEED, 24'h007FFF);
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_SPEED, 24'hA50080);
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_PAUSE, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_RESUME, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_SPEED, 24'h008000);
      issue(OP_STOP, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_PLAY, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_MODE, FIELD_W'(MODE_ONCE));
      issue(OP_SET_FRM, 24'd6, PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_MODE, {22'h155555, MODE_SPARE});
      write_reg(CSR_SPEED, 24'h000100);
      issue(OP_PLAY, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_SET_FRM, 24'd7, PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_UNUSED, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_MODE, FIELD_W'(MODE_WRAP));
      write_reg(CSR_SPEED, 24'h000000);
      write_reg(CSR_TOTAL, 24'd100);
      issue(OP_SET_FRM, 24'd50, PCT_W'($urandom));
      issue(OP_PLAY, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_TOTAL, 24'd10);
      issue(OP_UNUSED, FIELD_W'($urandom), PCT_W'($urandom));
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_SPEED, 24'h00FF00);
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));
      write_reg(CSR_SPARE, 24'hFFFFFF);
      issue(OP_TICK, FIELD_W'($urandom), PCT_W'($urandom));

      for (int phase = 0; phase < 25; phase++) begin
         settle();
         idle_pct <= (phase >= 22) ? 0 : $urandom_range(0, 3) * 15;
         case ($urandom_range(0, 9))
            0:       total = '0;
            1:       total = '1;
            2, 3:    total = FIELD_W'($urandom);
            default: total = FIELD_W'($urandom_range(1, 40));
         endcase
         write_reg(CSR_TOTAL, total);
         if ($urandom_range(0, 9) < 7) begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : MODE_W'($urandom_range(0, 2));
            word = FIELD_W'($urandom);
            word[MODE_W-1:0] = mode;
            write_reg(CSR_MODE, word);
         end
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0:       spd = 16'h8000;
               1:       spd = 16'h7FFF;
               2:       spd = '0;
               3, 4:    spd = SPEED_W'($urandom);
               default: begin
                  mag = $urandom_range(1, 2048);
                  spd = $urandom_range(0, 1) ? SPEED_W'(-mag) : SPEED_W'(mag);
               end
            endcase
            word = FIELD_W'($urandom);
            word[SPEED_W-1:0] = spd;
            write_reg(CSR_SPEED, word);
         end
         for (int n = 0; n < 40; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
               op = OP_TICK;
            else if (r < 62)
               op = $urandom_range(0, 1) ? OP_PLAY : OP_RESUME;
            else if (r < 67)
               op = OP_STOP;
            else if (r < 72)
               op = OP_PAUSE;
            else if (r < 84)
               op = OP_SET_FRM;
            else if (r < 96)
               op = OP_SET_POS;
            else
               op = OP_UNUSED;
            fv = $urandom_range(0, 1) ? FIELD_W'($urandom) :
                                        FIELD_W'($urandom_range(0, total + 2));
            issue(op, fv, PCT_W'($urandom));
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
